FILE: rtl/jerk_accel_velocity_limiter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the jerk, acceleration and velocity limiter
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef JERK_ACCEL_VELOCITY_LIMITER_TOP_DEFINES_SVH
`define JERK_ACCEL_VELOCITY_LIMITER_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define JALIM_ASSERT_NOW(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("limiter assertion failed");

// The condition must hold in the cycle after the trigger.
`define JALIM_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("limiter assertion failed");

`endif

FILE: rtl/jalim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter package
// Beat types, register indexes and shared helpers of the limiter.
// ----------------------------------------------------------------------------
package jalim_pkg;

	typedef enum logic [2:0] {
		REG_ENABLES = 3'd0,
		REG_VEL_MIN = 3'd1,
		REG_VEL_MAX = 3'd2,
		REG_ACC_MIN = 3'd3,
		REG_ACC_MAX = 3'd4,
		REG_JRK_MIN = 3'd5,
		REG_JRK_MAX = 3'd6
	} reg_idx_t;

	localparam int EN_VEL = 0;
	localparam int EN_ACC = 1;
	localparam int EN_JRK = 2;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_beat_t;

	typedef struct packed {
		logic signed [31:0] commanded_velocity;
		logic signed [31:0] previous_velocity;
		logic signed [31:0] older_velocity;
		logic [15:0]        time_step;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] limited_velocity;
		logic signed [31:0] scale_factor;
		logic               factor_saturated;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0] vel;
		logic signed [31:0] cmd;
	} div_req_t;

	localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
	localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
		logic signed [35:0] y;
		y = x;
		if (x > S32_MAX) y = S32_MAX;
		if (x < S32_MIN) y = S32_MIN;
		return y[31:0];
	endfunction

endpackage

FILE: rtl/jalim_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter stream interface
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
interface jalim_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/jalim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter ratio divider
// Pipelined restoring divider, four quotient bits per stage, with saturation.
// ----------------------------------------------------------------------------
module jalim_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  jalim_pkg::div_req_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output jalim_pkg::out_beat_t  rsp
);
	localparam int STEP = 4;
	localparam int QW   = ((32 + FRAC_BITS + STEP - 1) / STEP) * STEP;
	localparam int NS   = QW / STEP;
	localparam logic [QW-1:0] POS_LIM = QW'(32'h7FFF_FFFF);
	localparam logic [QW-1:0] NEG_LIM = QW'(32'h8000_0000);

	logic               vld_s [0:NS+1];
	logic               adv   [0:NS+1];
	logic [31:0]        rem_s [0:NS];
	logic [QW-1:0]      num_s [0:NS];
	logic [31:0]        dvs_s [0:NS];
	logic               neg_s [0:NS];
	logic               zero_s[0:NS];
	logic signed [31:0] vel_s [0:NS];
	jalim_pkg::out_beat_t rsp_s;

	logic [31:0] vmag;
	logic [31:0] cmag;

	assign adv[NS+1] = !vld_s[NS+1] || rsp_ready;
	assign req_ready = adv[0];
	assign rsp_valid = vld_s[NS+1];
	assign rsp       = rsp_s;

	assign vmag = req.vel[31] ? 32'(-req.vel) : 32'(req.vel);
	assign cmag = req.cmd[31] ? 32'(-req.cmd) : 32'(req.cmd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv[0]) begin
			vld_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0]  <= '0;
			num_s[0]  <= QW'({vmag, {FRAC_BITS{1'b0}}});
			dvs_s[0]  <= cmag;
			neg_s[0]  <= req.vel[31] ^ req.cmd[31];
			zero_s[0] <= (req.cmd == '0);
			vel_s[0]  <= req.vel;
		end
	end

	genvar k;
	generate
		for (k = 0; k <= NS; k++) begin : g_adv
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		for (k = 1; k <= NS; k++) begin : g_stage
			logic [31:0]   rem_d;
			logic [QW-1:0] num_d;

			always_comb begin
				logic [32:0]   r;
				logic [QW-1:0] n;
				r = {1'b0, rem_s[k-1]};
				n = num_s[k-1];
				for (int i = 0; i < STEP; i++) begin
					r = {r[31:0], n[QW-1]};
					n = {n[QW-2:0], 1'b0};
					if (r >= {1'b0, dvs_s[k-1]}) begin
						r = r - {1'b0, dvs_s[k-1]};
						n[0] = 1'b1;
					end
				end
				rem_d = r[31:0];
				num_d = n;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k]  <= rem_d;
					num_s[k]  <= num_d;
					dvs_s[k]  <= dvs_s[k-1];
					neg_s[k]  <= neg_s[k-1];
					zero_s[k] <= zero_s[k-1];
					vel_s[k]  <= vel_s[k-1];
				end
			end
		end
	endgenerate

	// Sign restore and clipping of the magnitude quotient; a zero command gives a factor of one.
	jalim_pkg::out_beat_t fin_d;
	always_comb begin
		logic [QW-1:0] q;
		q = num_s[NS];
		fin_d.limited_velocity = vel_s[NS];
		fin_d.factor_saturated = 1'b0;
		fin_d.scale_factor     = $signed(q[31:0]);
		if (zero_s[NS]) begin
			fin_d.scale_factor = $signed(32'd1 << FRAC_BITS);
		end else if (neg_s[NS]) begin
			if (q > NEG_LIM) begin
				fin_d.scale_factor     = $signed(32'h8000_0000);
				fin_d.factor_saturated = 1'b1;
			end else begin
				fin_d.scale_factor = $signed(32'(-q[31:0]));
			end
		end else if (q > POS_LIM) begin
			fin_d.scale_factor     = $signed(32'h7FFF_FFFF);
			fin_d.factor_saturated = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NS+1] <= 1'b0;
		end else if (adv[NS+1]) begin
			vld_s[NS+1] <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS+1]) begin
			rsp_s <= fin_d;
		end
	end

endmodule

FILE: rtl/jerk_accel_velocity_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jerk, acceleration and velocity limiter
// Clamps a commanded velocity by jerk, acceleration and velocity bounds and
// reports the ratio of limited to commanded velocity.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat contents
// cfg      in         register index, 32-bit write data
// sample   in         commanded, previous and older velocity, time step
// result   out        limited velocity, scale factor, saturation flag
//
// One beat is taken per cycle while the result channel is not stalled; the
// divider after stage 5 resolves four quotient bits per stage.
// Each stage holds its own valid bit, so a stalled result only backs up the
// stages behind it and bubbles are squeezed out.
// Reset clears the valid bits and the configuration registers; payload is not reset.
// Configuration is always ready and is meant to change only while idle.
// ----------------------------------------------------------------------------
`include "jerk_accel_velocity_limiter_top_defines.svh"

module jerk_accel_velocity_limiter_top #(
	parameter int FRAC_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	jalim_stream_if.sink   cfg,
	jalim_stream_if.sink   sample,
	jalim_stream_if.source result
);
	// Configuration registers.
	logic [2:0]         enables_q;
	logic signed [31:0] vel_min_q;
	logic signed [31:0] vel_max_q;
	logic signed [31:0] acc_min_q;
	logic signed [31:0] acc_max_q;
	logic signed [31:0] jrk_min_q;
	logic signed [31:0] jrk_max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q <= '0;
			vel_min_q <= '0;
			vel_max_q <= '0;
			acc_min_q <= '0;
			acc_max_q <= '0;
			jrk_min_q <= '0;
			jrk_max_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				jalim_pkg::REG_ENABLES: enables_q <= cfg.data.data[2:0];
				jalim_pkg::REG_VEL_MIN: vel_min_q <= $signed(cfg.data.data);
				jalim_pkg::REG_VEL_MAX: vel_max_q <= $signed(cfg.data.data);
				jalim_pkg::REG_ACC_MIN: acc_min_q <= $signed(cfg.data.data);
				jalim_pkg::REG_ACC_MAX: acc_max_q <= $signed(cfg.data.data);
				jalim_pkg::REG_JRK_MIN: jrk_min_q <= $signed(cfg.data.data);
				jalim_pkg::REG_JRK_MAX: jrk_max_q <= $signed(cfg.data.data);
				default: ;
			endcase
		end
	end

	// Stage valid bits and the ready chain running back from the divider.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic div_ready;

	assign adv5 = !vld_s5 || div_ready;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign sample.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= sample.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: square the time step and scale the acceleration bounds by it.
	logic signed [31:0] cmd_s1, v0_s1, v1_s1;
	logic [31:0]        dtsq_s1;
	logic signed [47:0] alo_s1, ahi_s1;
	logic signed [16:0] dt_sg;

	assign dt_sg = $signed({1'b0, sample.data.time_step});

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1  <= sample.data.commanded_velocity;
			v0_s1   <= sample.data.previous_velocity;
			v1_s1   <= sample.data.older_velocity;
			dtsq_s1 <= 32'(sample.data.time_step * sample.data.time_step);
			alo_s1  <= 48'(acc_min_q * dt_sg);
			ahi_s1  <= 48'(acc_max_q * dt_sg);
		end
	end

	// Stage 2: jerk bounds times dt squared; acceleration bounds floored to Q16.16.
	logic signed [31:0] cmd_s2, v0_s2, v1_s2;
	logic signed [63:0] jlo_s2, jhi_s2;
	logic signed [31:0] alo_s2, ahi_s2;
	logic signed [32:0] dtsq_sg;

	assign dtsq_sg = $signed({1'b0, dtsq_s1});

	always_ff @(posedge clk) begin
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			v0_s2  <= v0_s1;
			v1_s2  <= v1_s1;
			jlo_s2 <= 64'(jrk_min_q * dtsq_sg);
			jhi_s2 <= 64'(jrk_max_q * dtsq_sg);
			alo_s2 <= 32'(alo_s1 >>> 16);
			ahi_s2 <= 32'(ahi_s1 >>> 16);
		end
	end

	// Stage 3: jerk limit. The second difference is clamped and the velocity
	// rebuilt from it, saturated to 32 bits.
	logic signed [31:0] cmd_s3, v0_s3, vel_s3;
	logic signed [31:0] alo_s3, ahi_s3;
	logic signed [31:0] vel_jrk;

	always_comb begin
		logic signed [35:0] lo, hi, x, base;
		lo   = 36'(jlo_s2 >>> 31);
		hi   = 36'(jhi_s2 >>> 31);
		base = 36'(v0_s2) + 36'(v0_s2) - 36'(v1_s2);
		x    = 36'(cmd_s2) - base;
		if (x > hi) x = hi;
		if (x < lo) x = lo;
		vel_jrk = cmd_s2;
		if (enables_q[jalim_pkg::EN_JRK]) vel_jrk = jalim_pkg::sat32(base + x);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			cmd_s3 <= cmd_s2;
			v0_s3  <= v0_s2;
			vel_s3 <= vel_jrk;
			alo_s3 <= alo_s2;
			ahi_s3 <= ahi_s2;
		end
	end

	// Stage 4: acceleration limit on the change from the previous velocity.
	logic signed [31:0] cmd_s4, vel_s4;
	logic signed [31:0] vel_acc;

	always_comb begin
		logic signed [35:0] dv;
		dv = 36'(vel_s3) - 36'(v0_s3);
		if (dv > 36'(ahi_s3)) dv = 36'(ahi_s3);
		if (dv < 36'(alo_s3)) dv = 36'(alo_s3);
		vel_acc = vel_s3;
		if (enables_q[jalim_pkg::EN_ACC]) vel_acc = jalim_pkg::sat32(36'(v0_s3) + dv);
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			cmd_s4 <= cmd_s3;
			vel_s4 <= vel_acc;
		end
	end

	// Stage 5: velocity bounds; a crossed pair resolves to the minimum bound, vel_min_q.
	logic signed [31:0] cmd_s5, vel_s5;
	logic signed [31:0] vel_lim;

	always_comb begin
		vel_lim = vel_s4;
		if (enables_q[jalim_pkg::EN_VEL]) begin
			if (vel_lim > vel_max_q) vel_lim = vel_max_q;
			if (vel_lim < vel_min_q) vel_lim = vel_min_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			cmd_s5 <= cmd_s4;
			vel_s5 <= vel_lim;
		end
	end

	// Ratio divider; its last stage is the output register.
	jalim_pkg::div_req_t  div_req;
	jalim_pkg::out_beat_t div_rsp;

	assign div_req.vel = vel_s5;
	assign div_req.cmd = cmd_s5;

	jalim_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (vld_s5),
		.req_ready (div_ready),
		.req       (div_req),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.rsp       (div_rsp)
	);

	assign result.data = div_rsp;

	// A clipped ratio always sits on one of the two 32-bit rails.
	logic ratio_at_rail;
	assign ratio_at_rail = (result.data.scale_factor == 32'sh7FFF_FFFF) ||
		(result.data.scale_factor == 32'sh8000_0000);

	`JALIM_ASSERT_NEXT(a_accept_fills_s1, sample.valid && sample.ready, vld_s1)
	`JALIM_ASSERT_NEXT(a_s5_holds, vld_s5 && !div_ready, vld_s5 && $stable(vel_s5))
	`JALIM_ASSERT_NOW(a_sat_at_limit, result.valid && result.data.factor_saturated, ratio_at_rail)

endmodule
